>>> sv/telnet_stream_decoder_core_assert.svh
// Assertion macros shared by the Telnet decoder RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TELNET_STREAM_DECODER_CORE_ASSERT_SVH
`define TELNET_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset
`define TSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("telnet decoder assertion failed");

// Next-cycle implication, off during reset
`define TSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("telnet decoder assertion failed");

`endif

>>> sv/tsd_pkg.sv
// Shared types and constants for the Telnet stream decoder.
// No dependencies; the files that use it refer to this package by scoped name.
`default_nettype none

package tsd_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;
  // count field in the command word covers depths up to 127 (default 64)
  localparam int unsigned CNT_W             = 7;
  localparam int unsigned FIFO_DEPTH        = 2;
  localparam int unsigned FIFO_PTR_W        = 1;

  localparam logic [7:0] CODE_IAC  = 8'hFF;
  localparam logic [7:0] CODE_SB   = 8'hFA;
  localparam logic [7:0] CODE_SE   = 8'hF0;
  localparam logic [7:0] CODE_WILL = 8'hFB;
  localparam logic [7:0] CODE_DONT = 8'hFE;

  typedef enum logic [1:0] {
    EV_TEXT     = 2'd0,
    EV_NEG      = 2'd1,
    EV_SB_START = 2'd2,
    EV_SB_END   = 2'd3
  } evt_kind_t;

  typedef enum logic [2:0] {
    PS_NORMAL    = 3'd0,
    PS_AFTER_IAC = 3'd1,
    PS_AFTER_CMD = 3'd2,
    PS_SB_OPTION = 3'd3,
    PS_IN_SUB    = 3'd4,
    PS_SUB_IAC   = 3'd5
  } parse_state_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_FETCH = 2'd1,
    BK_LOAD  = 2'd2
  } back_state_t;

  // work item from parser to result engine
  typedef struct packed {
    evt_kind_t        kind;
    logic [7:0]       value;
    logic [7:0]       option;
    logic             escaped;
    logic             present;
    logic             ovf;
    logic [CNT_W-1:0] count;
  } tsd_cmd_t;

  typedef struct packed {
    evt_kind_t  kind;
    logic [7:0] value;
    logic [7:0] option;
    logic       escaped;
    logic       present;
    logic       ovf;
    logic       last;
  } tsd_res_t;

endpackage

`default_nettype wire

>>> sv/tsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/tsd_cmd_fifo.sv
// Short command queue between the parser and the result engine.
// Depends on tsd_pkg for the command type and depth.
`default_nettype none

module tsd_cmd_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tsd_pkg::tsd_cmd_t  din,
  output logic                    full,
  input  wire logic               pop,
  output tsd_pkg::tsd_cmd_t       dout,
  output logic                    valid
);

  localparam int unsigned PW = tsd_pkg::FIFO_PTR_W;

  tsd_pkg::tsd_cmd_t entry_r [tsd_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign full    = (fill_r == (PW+1)'(tsd_pkg::FIFO_DEPTH));
  assign valid   = (fill_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

>>> sv/tsd_front.sv
// Parser front end: accepts stream bytes, runs the IAC state machine,
// writes subnegotiation payload to the RAM and queues work for the back end.
// Depends on tsd_pkg.
`default_nettype none

module tsd_front #(
  parameter int unsigned PAYLOAD_DEPTH = tsd_pkg::PAYLOAD_DEPTH_DEF,
  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1,
  localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_tdata,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output tsd_pkg::tsd_cmd_t  cmd,
  output logic               cmd_push,
  input  wire logic          fifo_full,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [7:0]         ram_wdata,
  input  wire logic          replay_done
);

  tsd_pkg::parse_state_t state_r, state_nxt;
  logic [7:0]    cmd_held_r, opt_r, second_byte_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          end_pend_r, end_pend_nxt;
  logic          second_pend_r, second_pend_nxt;

  logic       accept;
  logic       store_req, can_store, clr_sub, set_end, load_cmd, load_opt, second_set;
  logic [7:0] store_byte;
  logic       is_neg;

  assign in_tready = !end_pend_r && !second_pend_r && !fifo_full;
  assign accept    = in_tvalid && in_tready;
  assign is_neg    = (in_tdata >= tsd_pkg::CODE_WILL) && (in_tdata <= tsd_pkg::CODE_DONT);

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      unique case (state_r)
        tsd_pkg::PS_AFTER_IAC: begin
          if (in_tdata == tsd_pkg::CODE_IAC) begin
            state_nxt = tsd_pkg::PS_NORMAL;
          end else if (is_neg) begin
            state_nxt = tsd_pkg::PS_AFTER_CMD;
          end else if (in_tdata == tsd_pkg::CODE_SB) begin
            state_nxt = tsd_pkg::PS_SB_OPTION;
          end else begin
            state_nxt = tsd_pkg::PS_NORMAL;
          end
        end
        tsd_pkg::PS_AFTER_CMD: state_nxt = tsd_pkg::PS_NORMAL;
        tsd_pkg::PS_SB_OPTION: state_nxt = tsd_pkg::PS_IN_SUB;
        tsd_pkg::PS_IN_SUB: begin
          state_nxt = (in_tdata == tsd_pkg::CODE_IAC) ? tsd_pkg::PS_SUB_IAC
                                                      : tsd_pkg::PS_IN_SUB;
        end
        tsd_pkg::PS_SUB_IAC: begin
          state_nxt = (in_tdata == tsd_pkg::CODE_SE) ? tsd_pkg::PS_NORMAL
                                                     : tsd_pkg::PS_IN_SUB;
        end
        default: begin
          state_nxt = (in_tdata == tsd_pkg::CODE_IAC) ? tsd_pkg::PS_AFTER_IAC
                                                      : tsd_pkg::PS_NORMAL;
        end
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd_push   = 1'b0;
    store_req  = 1'b0;
    store_byte = in_tdata;
    clr_sub    = 1'b0;
    set_end    = 1'b0;
    load_cmd   = 1'b0;
    load_opt   = 1'b0;
    second_set = 1'b0;
    if (second_pend_r) begin
      // second half of a stray IAC pair
      store_req  = 1'b1;
      store_byte = second_byte_r;
    end else if (accept) begin
      unique case (state_r)
        tsd_pkg::PS_AFTER_IAC: begin
          if (in_tdata == tsd_pkg::CODE_IAC) begin
            cmd_push    = 1'b1;
            cmd.kind    = tsd_pkg::EV_TEXT;
            cmd.value   = tsd_pkg::CODE_IAC;
            cmd.escaped = 1'b1;
            cmd.present = 1'b1;
          end else if (is_neg) begin
            load_cmd = 1'b1;
          end else if (in_tdata == tsd_pkg::CODE_SB) begin
            clr_sub = 1'b1;
          end
        end
        tsd_pkg::PS_AFTER_CMD: begin
          cmd_push    = 1'b1;
          cmd.kind    = tsd_pkg::EV_NEG;
          cmd.value   = cmd_held_r;
          cmd.option  = in_tdata;
          cmd.present = 1'b1;
        end
        tsd_pkg::PS_SB_OPTION: begin
          load_opt   = 1'b1;
          cmd_push   = 1'b1;
          cmd.kind   = tsd_pkg::EV_SB_START;
          cmd.option = in_tdata;
        end
        tsd_pkg::PS_IN_SUB: begin
          store_req = (in_tdata != tsd_pkg::CODE_IAC);
        end
        tsd_pkg::PS_SUB_IAC: begin
          if (in_tdata == tsd_pkg::CODE_IAC) begin
            store_req  = 1'b1;
            store_byte = tsd_pkg::CODE_IAC;
          end else if (in_tdata == tsd_pkg::CODE_SE) begin
            cmd_push   = 1'b1;
            cmd.kind   = tsd_pkg::EV_SB_END;
            cmd.option = opt_r;
            cmd.ovf    = ovf_r;
            cmd.count  = tsd_pkg::CNT_W'(count_r);
            clr_sub    = 1'b1;
            set_end    = 1'b1;
          end else begin
            store_req  = 1'b1;
            store_byte = tsd_pkg::CODE_IAC;
            second_set = 1'b1;
          end
        end
        default: begin
          if (in_tdata != tsd_pkg::CODE_IAC) begin
            cmd_push    = 1'b1;
            cmd.kind    = tsd_pkg::EV_TEXT;
            cmd.value   = in_tdata;
            cmd.present = 1'b1;
          end
        end
      endcase
    end
  end

  assign can_store = (count_r != CW'(PAYLOAD_DEPTH));
  assign ram_we    = store_req && can_store;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = store_byte;

  always_comb begin
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    if (clr_sub) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (ram_we) begin
      count_nxt = count_r + CW'(1);
    end else if (store_req) begin
      ovf_nxt = 1'b1;
    end
    end_pend_nxt    = set_end ? 1'b1 : (replay_done ? 1'b0 : end_pend_r);
    second_pend_nxt = second_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tsd_pkg::PS_NORMAL;
      count_r       <= '0;
      ovf_r         <= 1'b0;
      end_pend_r    <= 1'b0;
      second_pend_r <= 1'b0;
      cmd_held_r    <= '0;
      opt_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      ovf_r         <= ovf_nxt;
      end_pend_r    <= end_pend_nxt;
      second_pend_r <= second_pend_nxt;
      if (load_cmd) begin
        cmd_held_r <= in_tdata;
      end
      if (load_opt) begin
        opt_r <= in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (second_set) begin
      second_byte_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

>>> sv/tsd_back.sv
// Result engine: pops queued work, drives the output register and replays
// buffered payload from the RAM at subnegotiation end. Depends on tsd_pkg.
`default_nettype none

module tsd_back #(
  parameter int unsigned PAYLOAD_DEPTH = tsd_pkg::PAYLOAD_DEPTH_DEF,
  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tsd_pkg::tsd_cmd_t  cmd,
  input  wire logic               cmd_valid,
  output logic                    cmd_pop,
  output logic                    ram_re,
  output logic [AW-1:0]           ram_raddr,
  input  wire logic [7:0]         ram_rdata,
  output logic                    replay_done,
  output tsd_pkg::tsd_res_t       res,
  output logic                    res_valid,
  input  wire logic               res_ready
);

  localparam int unsigned NW = tsd_pkg::CNT_W;

  tsd_pkg::back_state_t st_r, st_nxt;
  logic [NW-1:0]     idx_r, idx_nxt, cnt_r;
  logic [7:0]        opt_r;
  logic              ovf_r;
  tsd_pkg::tsd_res_t res_r, res_nxt;
  logic              res_valid_r, res_valid_nxt;

  logic load_ok, load_res, start_replay, step, last_byte, cmd_direct;

  assign load_ok    = !res_valid_r || res_ready;
  assign last_byte  = ((idx_r + NW'(1)) == cnt_r);
  assign cmd_direct = (cmd.kind != tsd_pkg::EV_SB_END) || (cmd.count == '0);
  assign ram_raddr  = idx_r[AW-1:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      tsd_pkg::BK_IDLE: begin
        if (cmd_valid && !cmd_direct) begin
          st_nxt = tsd_pkg::BK_FETCH;
        end
      end
      tsd_pkg::BK_FETCH: st_nxt = tsd_pkg::BK_LOAD;
      tsd_pkg::BK_LOAD: begin
        if (load_ok) begin
          st_nxt = last_byte ? tsd_pkg::BK_IDLE : tsd_pkg::BK_FETCH;
        end
      end
      default: st_nxt = tsd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop      = 1'b0;
    ram_re       = 1'b0;
    load_res     = 1'b0;
    start_replay = 1'b0;
    step         = 1'b0;
    replay_done  = 1'b0;
    res_nxt      = res_r;
    unique case (st_r)
      tsd_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (!cmd_direct) begin
            cmd_pop      = 1'b1;
            start_replay = 1'b1;
          end else if (load_ok) begin
            cmd_pop         = 1'b1;
            load_res        = 1'b1;
            res_nxt.kind    = cmd.kind;
            res_nxt.value   = cmd.value;
            res_nxt.option  = cmd.option;
            res_nxt.escaped = cmd.escaped;
            res_nxt.present = cmd.present;
            res_nxt.ovf     = cmd.ovf;
            res_nxt.last    = 1'b1;
            replay_done     = (cmd.kind == tsd_pkg::EV_SB_END);
          end
        end
      end
      tsd_pkg::BK_FETCH: ram_re = 1'b1;
      tsd_pkg::BK_LOAD: begin
        if (load_ok) begin
          load_res        = 1'b1;
          step            = 1'b1;
          res_nxt.kind    = tsd_pkg::EV_SB_END;
          res_nxt.value   = ram_rdata;
          res_nxt.option  = opt_r;
          res_nxt.escaped = 1'b0;
          res_nxt.present = 1'b1;
          res_nxt.ovf     = ovf_r;
          res_nxt.last    = last_byte;
          replay_done     = last_byte;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_nxt       = start_replay ? '0 : (step ? idx_r + NW'(1) : idx_r);
    res_valid_nxt = load_res ? 1'b1 : (res_ready ? 1'b0 : res_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tsd_pkg::BK_IDLE;
      res_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      res_valid_r <= res_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_replay) begin
      cnt_r <= cmd.count;
      opt_r <= cmd.option;
      ovf_r <= cmd.ovf;
    end
    if (load_res) begin
      res_r <= res_nxt;
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

`default_nettype wire

>>> sv/telnet_stream_decoder_core.sv
// Telnet IAC stream decoder, top level.
// Input: one received byte per transfer on in_tdata. Output: one result per
// transfer; out_tlast marks the final result caused by an input byte.
// Path: a byte's result passes the command queue write, then the output
// register; the first end result of a replay passes the queue, then the
// engine's fetch state (RAM read) and load state (output register).
// Throughput: one byte per cycle for text and negotiation traffic while
// the command queue has room. A stray IAC inside a subnegotiation writes
// two payload bytes through the single RAM write port and holds off input
// for the second. At IAC SE input waits until the last end result is loaded
// while the payload is read back from RAM (address, then registered data).
// The two-entry command queue decouples parser and result engine, so bytes
// keep flowing while a result waits in the output register.
// Receiver stall: out_tvalid and its payload hold; once the queue fills,
// in_tready drops.
// Reset (rst_n low, synchronous): parser to normal text, queue and output
// emptied. Payload RAM is not cleared; only written entries are read.
`default_nettype none
`include "telnet_stream_decoder_core_assert.svh"

module telnet_stream_decoder_core #(
  parameter int unsigned PAYLOAD_DEPTH = tsd_pkg::PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata[7:0] data_byte
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata[7:0] value_byte, [15:8] option_code, [16] payload_overflow
  output logic [23:0]      out_tdata,
  // out_tuser[1:0] event_kind, [2] was_escaped, [3] byte_present
  output logic [3:0]       out_tuser,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  tsd_pkg::tsd_cmd_t fe_cmd, q_cmd;
  tsd_pkg::tsd_res_t res;
  logic          fe_push, q_full, q_valid, q_pop;
  logic          ram_we, ram_re, replay_done;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  tsd_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .cmd         (fe_cmd),
    .cmd_push    (fe_push),
    .fifo_full   (q_full),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .replay_done (replay_done)
  );

  tsd_cmd_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .din   (fe_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .valid (q_valid)
  );

  tsd_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsd_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (q_cmd),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .replay_done (replay_done),
    .res         (res),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready)
  );

  assign out_tdata = {7'b0, res.ovf, res.option, res.value};
  assign out_tuser = {res.present, res.escaped, res.kind};
  assign out_tlast = res.last;

  `TSD_ASSERT_IMP(a_full_blocks_input, q_full, !in_tready)
  `TSD_ASSERT_IMP(a_pop_needs_entry, q_pop, q_valid)
  `TSD_ASSERT_IMP(a_escaped_is_iac, out_tvalid && res.escaped, res.value == tsd_pkg::CODE_IAC)
  `TSD_ASSERT_IMP(a_escaped_is_text, out_tvalid && res.escaped, res.kind == tsd_pkg::EV_TEXT)
  `TSD_ASSERT_IMP(a_single_results_last, out_tvalid && (res.kind != tsd_pkg::EV_SB_END), res.last)

endmodule

`default_nettype wire
